// ===== rtl/core/apln_pkg.sv =====
// Package for the audio power log normalizer core.
// Holds constants shared by the core and the bench.
package apln_pkg;
    localparam logic [31:0] Ln2Q32 = 32'd2977044472;
    localparam logic [30:0] OneQ30 = 31'h4000_0000;
    localparam logic [21:0] OneQ20 = 22'd1048576;
    localparam logic [15:0] Recip3Q16 = 16'd21846;
    localparam logic [1:0] CfgNormEnable = 2'd0;
    localparam logic [1:0] CfgSmoothingRate = 2'd1;
    localparam logic [1:0] CfgLevelScale = 2'd2;
endpackage

// ===== rtl/core/audio_power_log_normalizer_core.sv =====
// Audio power log normalizer: top level with sequencer and shared datapath.
// Depends on apln_pkg.
// With normalization enabled a sample runs through 4 power steps, 25 root and 52 ratio steps,
// then 32 log squaring and up to 30 gain division steps for larger ratios; when off, only scaling.
// A new sample waits until the last output is accepted; s_tready is low while busy or holding.
// Reset (synchronous, active low) clears power and control state and restores config defaults.
module audio_power_log_normalizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_sample[23:0]
    input  logic        s_tuser,   // mute
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // out_sample[21:0], zero fill
);
    localparam logic [3:0] StIdle = 4'd0, StPow1 = 4'd1, StPow2 = 4'd2,
        StSqrt = 4'd3, StDiv = 4'd4, StGain = 4'd5, StLog = 4'd6,
        StLn1 = 4'd7, StLn2 = 4'd8, StGdiv = 4'd9, StScale = 4'd10,
        StOut = 4'd11, StSmall = 4'd12, StPow3 = 4'd13, StPow4 = 4'd14;

    logic [3:0] state_reg, state_next;
    logic en_reg; logic [16:0] tau_reg; logic [23:0] delta_reg;
    logic [47:0] pow_reg;
    logic neg_reg, mute_reg;
    logic [23:0] mag_reg;
    logic [63:0] acc_reg;   // general accumulator / remainder
    logic [63:0] aux_reg;   // root result, quotient, mantissa
    logic [63:0] bit_reg;
    logic [5:0] cnt_reg;
    logic [63:0] x_reg;
    logic [31:0] frac_reg;
    logic [4:0] ex_reg;
    logic [30:0] g_reg;
    logic [21:0] out_reg;
    logic outv_reg;

    logic [16:0] tau_c; logic [23:0] delta_c; logic [16:0] keep_c;
    assign tau_c = (tau_reg > 17'd65536) ? 17'd65536 : tau_reg;
    assign delta_c = (delta_reg == 24'd0) ? 24'd1 : delta_reg;
    assign keep_c = 17'd65536 - tau_c;

    logic [47:0] sq;
    assign sq = 48'(mag_reg) * 48'(mag_reg);

    assign s_tready = (state_reg == StIdle) && !outv_reg;
    assign m_tvalid = outv_reg;
    assign m_tdata = {2'b00, out_reg};

    logic [63:0] msq;
    assign msq = (aux_reg[32:0] * aux_reg[32:0]) >> 31;
    logic [14:0] xsq;
    assign xsq = 15'((48'(x_reg[23:0]) * 48'(x_reg[23:0])) >> 34);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle; en_reg <= 1'b0; tau_reg <= 17'd32768;
            delta_reg <= 24'd32768; pow_reg <= '0; outv_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    apln_pkg::CfgNormEnable: en_reg <= cfg_data[0];
                    apln_pkg::CfgSmoothingRate: tau_reg <= cfg_data[16:0];
                    apln_pkg::CfgLevelScale: delta_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (outv_reg && m_tready) outv_reg <= 1'b0;
            unique case (state_reg)
                StIdle: if (s_tvalid && s_tready) begin
                    neg_reg <= s_tdata[23];
                    mag_reg <= s_tdata[23] ? 24'(-s_tdata) : s_tdata;
                    mute_reg <= s_tuser;
                    g_reg <= apln_pkg::OneQ30;
                    state_reg <= en_reg ? StPow1 : StScale;
                end
                StPow1: begin
                    acc_reg <= 64'(keep_c) * 64'(pow_reg[23:0]);
                    state_reg <= StPow2;
                end
                StPow2: begin
                    acc_reg <= acc_reg + ((64'(keep_c) * 64'(pow_reg[47:24])) << 24);
                    state_reg <= StPow3;
                end
                StPow3: begin
                    acc_reg <= acc_reg + 64'(tau_c) * 64'(sq[23:0]);
                    state_reg <= StPow4;
                end
                StPow4: begin
                    pow_reg <= 48'((acc_reg + ((64'(tau_c) * 64'(sq[47:24])) << 24)) >> 16);
                    aux_reg <= '0; bit_reg <= 64'd1 << 46;
                    state_reg <= StSqrt;
                end
                StSqrt: begin
                    if (bit_reg == 0) begin
                        acc_reg <= '0; x_reg <= aux_reg << 28; aux_reg <= '0;
                        cnt_reg <= 6'd0; state_reg <= StDiv;
                    end else begin
                        logic [63:0] v;
                        v = (bit_reg == 64'(1) << 46) ? 64'(pow_reg) : acc_reg;
                        if (v >= aux_reg + bit_reg) begin
                            acc_reg <= v - (aux_reg + bit_reg);
                            aux_reg <= (aux_reg >> 1) + bit_reg;
                        end else begin
                            acc_reg <= v; aux_reg <= aux_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                StDiv: begin
                    logic [63:0] r;
                    r = {acc_reg[62:0], x_reg[6'd51 - cnt_reg]};
                    if (r >= 64'(delta_c)) begin
                        acc_reg <= r - 64'(delta_c);
                        aux_reg <= {aux_reg[62:0], 1'b1};
                    end else begin
                        acc_reg <= r; aux_reg <= {aux_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd51) state_reg <= StGain;
                end
                StGain: begin
                    x_reg <= aux_reg;
                    if (aux_reg == 0) state_reg <= StScale;
                    else if (aux_reg < 64'd16777216) state_reg <= StSmall;
                    else begin
                        logic [63:0] y; logic [4:0] p;
                        y = 64'd1 << 32; y = y + aux_reg; p = 5'd0;
                        for (int i = 1; i < 31; i++)
                            if (y >> (32 + i) != 0) p = 5'(i);
                        ex_reg <= p;
                        aux_reg <= y >> (p + 1);
                        frac_reg <= '0; cnt_reg <= 6'd0; state_reg <= StLog;
                    end
                end
                StSmall: begin
                    logic [63:0] gs;
                    gs = 64'(apln_pkg::OneQ30) - (x_reg >> 3)
                        + 64'((32'(xsq) * 32'(apln_pkg::Recip3Q16)) >> 16);
                    g_reg <= (gs > 64'(apln_pkg::OneQ30)) ? apln_pkg::OneQ30 : 31'(gs);
                    state_reg <= StScale;
                end
                StLog: begin
                    if (msq >= 64'd1 << 32) begin
                        aux_reg <= msq >> 1; frac_reg <= {frac_reg[30:0], 1'b1};
                    end else begin
                        aux_reg <= msq; frac_reg <= {frac_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) state_reg <= StLn1;
                end
                StLn1: begin
                    acc_reg <= (64'(frac_reg) * 64'(apln_pkg::Ln2Q32)) >> 32;
                    state_reg <= StLn2;
                end
                StLn2: begin
                    logic [63:0] ln;
                    ln = acc_reg + 64'(ex_reg) * 64'(apln_pkg::Ln2Q32);
                    acc_reg <= ln; aux_reg <= '0; cnt_reg <= 6'd0;
                    if (ln >= x_reg) state_reg <= StScale;
                    else state_reg <= StGdiv;
                end
                StGdiv: begin
                    logic [63:0] r;
                    r = acc_reg << 1;
                    if (r >= x_reg) begin
                        acc_reg <= r - x_reg; aux_reg <= {aux_reg[62:0], 1'b1};
                    end else begin
                        acc_reg <= r; aux_reg <= {aux_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd29) state_reg <= StOut;
                end
                StOut: begin
                    g_reg <= aux_reg[30:0];
                    state_reg <= StScale;
                end
                StScale: begin
                    logic [54:0] pr; logic [23:0] m; logic [21:0] c;
                    pr = 55'(mag_reg) * 55'(g_reg);
                    m = 24'(pr >> 30);
                    c = (m > 24'(apln_pkg::OneQ20)) ? apln_pkg::OneQ20 : m[21:0];
                    out_reg <= mute_reg ? 22'd0 : (neg_reg ? -c : c);
                    outv_reg <= 1'b1;
                    state_reg <= StIdle;
                end
                default: state_reg <= StIdle;
            endcase
        end
    end

    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid);
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[21:0]) <= 22'sd1048576
            && $signed(m_tdata[21:0]) >= -22'sd1048576));
    a_out_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:22] == 2'b00);
    a_state_known: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg <= StPow4);
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for audio_power_log_normalizer_core: directed table, then random
// beats under varied stalls; each output checked against its row or a bit-exact gain predictor.
// Depends on apln_pkg and the core RTL only.
module tb_top;
    localparam logic [1:0] CfgUnused = 2'd3;
    localparam int CycleLimit = 1500000;

    typedef enum logic {RowBeat, RowWrite} row_kind_t;
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  index;
        logic [23:0] value;
        logic [23:0] sample;
        logic        mute;
        logic        known;
        logic [21:0] result;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // predictor state
    logic                norm_on;
    logic [16:0]         tau_reg;
    logic [23:0]         delta_reg;
    longint unsigned     power_acc;

    logic [21:0] out_queue[$];
    stim_row_t   rows[$];
    int          err_cnt = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    audio_power_log_normalizer_core dut (.*);

    always #5 aclk = ~aclk;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 46;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned log2_fix32(longint unsigned y);
        int p = 32;
        longint unsigned m;
        longint unsigned frac = 0;
        while (p < 62 && (y >> (p + 1)) != 0) p++;
        m = y >> (p - 31);
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac <<= 1;
            if (m >= (64'd1 << 32)) begin
                m >>= 1;
                frac |= 1;
            end
        end
        return (longint'(p - 32) << 32) | frac;
    endfunction

    function automatic longint unsigned log_gain(longint unsigned x);
        longint unsigned g, lg, ln, rem, q;
        if (x < (64'd1 << 24)) begin
            g = 64'd1073741824 - (x >> 3) + ((x * x) >> 34) / 3;
        end else begin
            lg = log2_fix32((64'd1 << 32) + x);
            ln = (lg >> 32) * 64'(apln_pkg::Ln2Q32)
                 + (((lg & 64'hFFFF_FFFF) * 64'(apln_pkg::Ln2Q32)) >> 32);
            if (ln >= x) begin
                g = 64'(apln_pkg::OneQ30);
            end else begin
                rem = ln;
                q = 0;
                for (int i = 0; i < 30; i++) begin
                    rem <<= 1;
                    q <<= 1;
                    if (rem >= x) begin
                        rem -= x;
                        q |= 1;
                    end
                end
                g = q;
            end
        end
        if (g > 64'(apln_pkg::OneQ30)) g = 64'(apln_pkg::OneQ30);
        return g;
    endfunction

    function automatic logic [21:0] normalize_sample(logic [23:0] raw, logic mute);
        logic neg = raw[23];
        longint unsigned mag = neg ? (64'h100_0000 - 64'(raw)) : 64'(raw);
        longint unsigned tau, delta, r, x;
        longint y;
        if (norm_on) begin
            tau = (tau_reg > 17'd65536) ? 64'd65536 : 64'(tau_reg);
            delta = (delta_reg == 0) ? 64'd1 : 64'(delta_reg);
            power_acc = (((64'd65536 - tau) * power_acc + tau * (mag * mag)) >> 16)
                        & 64'hFFFF_FFFF_FFFF;
            r = int_root(power_acc);
            x = (r << 28) / delta;
            if (x > 0) mag = (mag * log_gain(x)) >> 30;
        end
        y = neg ? -longint'(mag) : longint'(mag);
        if (y > 1048576) y = 1048576;
        if (y < -1048576) y = -1048576;
        if (mute) y = 0;
        return y[21:0];
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [23:0] val);
        wait (out_queue.size() == 0);
        repeat (8) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            apln_pkg::CfgNormEnable:    norm_on = val[0];
            apln_pkg::CfgSmoothingRate: tau_reg = val[16:0];
            apln_pkg::CfgLevelScale:    delta_reg = val;
            default: ;
        endcase
    endtask

    task automatic send_beat(logic [23:0] smp, logic mute, logic known, logic [21:0] res);
        logic [21:0] pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tuser <= mute;
        do @(posedge aclk); while (!s_tready);
        pred = normalize_sample(smp, mute);
        out_queue.push_back(known ? res : pred);
    endtask

    function automatic void add_row(row_kind_t k, logic [1:0] idx, logic [23:0] val,
                                    logic [23:0] smp, logic mute, logic known,
                                    logic [21:0] res);
        stim_row_t row;
        row.kind = k; row.index = idx; row.value = val;
        row.sample = smp; row.mute = mute; row.known = known; row.result = res;
        rows.push_back(row);
    endfunction

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return 24'(int'($urandom_range(2097152)) - 1048576);
            2: return 24'(int'($urandom_range(4096)) - 2048);
            default: return $urandom_range(1) ? 24'h7FFFFF - 24'($urandom_range(255))
                                              : 24'h800000 + 24'($urandom_range(255));
        endcase
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        logic [21:0] want;
        if (m_tvalid && m_tready) begin
            if (out_queue.size() == 0) begin
                $error("unexpected out_sample beat: actual %0d", $signed(m_tdata[21:0]));
                err_cnt <= err_cnt + 1;
            end else begin
                want = out_queue.pop_front();
                if (m_tdata[21:0] !== want) begin
                    $error("out_sample mismatch: expected %0d actual %0d",
                           $signed(want), $signed(m_tdata[21:0]));
                    err_cnt <= err_cnt + 1;
                end
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        norm_on = 1'b0;
        tau_reg = 17'd32768;
        delta_reg = 24'd32768;
        power_acc = 0;

        // bypass after reset: clip and mute readable directly
        add_row(RowBeat, 0, 0, 24'h7FFFFF, 0, 1, 22'd1048576);
        add_row(RowBeat, 0, 0, 24'h800000, 0, 1, -22'sd1048576);
        add_row(RowBeat, 0, 0, 24'd1048577, 0, 1, 22'd1048576);
        add_row(RowBeat, 0, 0, -24'sd1048577, 0, 1, -22'sd1048576);
        add_row(RowBeat, 0, 0, 24'd1000, 0, 1, 22'd1000);
        add_row(RowBeat, 0, 0, -24'sd1000, 0, 1, -22'sd1000);
        add_row(RowBeat, 0, 0, 24'h7FFFFF, 1, 1, 22'd0);
        add_row(RowWrite, CfgUnused, 24'hFFFFFF, 0, 0, 0, 0);
        add_row(RowBeat, 0, 0, 24'd0, 0, 1, 22'd0);
        add_row(RowWrite, apln_pkg::CfgNormEnable, 24'd1, 0, 0, 0, 0);
        add_row(RowBeat, 0, 0, 24'd0, 0, 0, 0);
        add_row(RowBeat, 0, 0, 24'd524288, 0, 0, 0);
        add_row(RowBeat, 0, 0, 24'h800000, 1, 0, 0);
        add_row(RowBeat, 0, 0, 24'h7FFFFF, 0, 0, 0);
        add_row(RowWrite, apln_pkg::CfgSmoothingRate, 24'd131071, 0, 0, 0, 0);
        add_row(RowWrite, apln_pkg::CfgLevelScale, 24'd0, 0, 0, 0, 0);
        add_row(RowBeat, 0, 0, -24'sd300000, 0, 0, 0);
        add_row(RowBeat, 0, 0, 24'd1, 0, 0, 0);
        add_row(RowWrite, apln_pkg::CfgSmoothingRate, 24'd0, 0, 0, 0, 0);
        add_row(RowBeat, 0, 0, 24'd700000, 0, 0, 0);
        add_row(RowWrite, apln_pkg::CfgLevelScale, 24'hFFFFFF, 0, 0, 0, 0);
        add_row(RowWrite, apln_pkg::CfgSmoothingRate, 24'd65536, 0, 0, 0, 0);
        add_row(RowBeat, 0, 0, 24'h7FFFFF, 0, 0, 0);
        add_row(RowBeat, 0, 0, -24'sd5, 0, 0, 0);
        add_row(RowBeat, 0, 0, 24'd200000, 1, 0, 0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == RowWrite) begin
                s_tvalid <= 1'b0;
                reg_write(rows[i].index, rows[i].value);
            end else begin
                send_beat(rows[i].sample, rows[i].mute, rows[i].known, rows[i].result);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int blk = 0; blk < 3; blk++) begin
                s_tvalid <= 1'b0;
                reg_write(apln_pkg::CfgNormEnable, ($urandom_range(5) != 0) ? 24'd1 : 24'd0);
                case ($urandom_range(3))
                    0: reg_write(apln_pkg::CfgSmoothingRate, 24'd0);
                    1: reg_write(apln_pkg::CfgSmoothingRate, 24'd131071);
                    default: reg_write(apln_pkg::CfgSmoothingRate,
                                       24'($urandom_range(65536)));
                endcase
                case ($urandom_range(4))
                    0: reg_write(apln_pkg::CfgLevelScale, 24'd0);
                    1: reg_write(apln_pkg::CfgLevelScale, 24'hFFFFFF);
                    2: reg_write(apln_pkg::CfgLevelScale,
                                 24'($urandom_range(16777215, 4194304)));
                    default: reg_write(apln_pkg::CfgLevelScale,
                                       24'($urandom_range(262144, 1)));
                endcase
                for (int n = 0; n < 75; n++) begin
                    if (ph == 0 && blk == 1 && n == 10) hold_req <= hold_req + 1;
                    send_beat(rand_sample(), $urandom_range(9) == 0, 1'b0, '0);
                end
            end
        end
        s_tvalid <= 1'b0;

        wait (out_queue.size() == 0);
        repeat (250) @(posedge aclk);
        if (err_cnt == 0 && out_queue.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/apln_pkg.sv
rtl/core/audio_power_log_normalizer_core.sv
bench/tb_top.sv
